### src/rnra_pkg.sv
// Shared types and constants of the ring neighbour resource arbiter.
`default_nettype none
package rnra_pkg;

    localparam int MAX_SEATS_DEF = 8;   // default ring size
    localparam int SEAT_W        = 3;   // width of the seat field
    localparam int COUNT_W       = 4;   // width of the seat_count register
    localparam int MASK_W        = 8;   // width of the eating and hungry masks
    localparam int STATUS_W      = 2;
    localparam int S_DATA_W      = 8;   // operation + seat, padded to a byte
    localparam int M_DATA_W      = 24;  // 21 result bits, padded to whole bytes

    localparam logic [COUNT_W-1:0] SEAT_COUNT_RST = 4'd8;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_STATE = 2'd2;

    // operation codes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        SEAT_THINK  = 2'd0,
        SEAT_HUNGRY = 2'd1,
        SEAT_EAT    = 2'd2
    } seat_state_t;

    // what a cell shows its ring neighbors in the current cycle
    typedef struct packed {
        seat_state_t state;    // current seat state
        logic        rel;      // this seat is releasing in this cycle
        logic        grant_l;  // granted as left neighbor of a releasing seat
    } link_t;

    // what a cell reports toward the result word
    typedef struct packed {
        logic err;       // operation invalid in the seat's state
        logic self_g;    // request granted at once
        logic left_g;    // began eating as left neighbor of the releaser
        logic right_g;   // began eating as right neighbor of the releaser
    } report_t;

endpackage
`default_nettype wire

### src/rnra_cell.sv
// One seat of the ring: holds its state and decides grants from its neighbors.
`default_nettype none
module rnra_cell #(
    parameter int IDX = 0,
    parameter int CW  = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 fire,
    input  wire logic                 op,
    input  wire logic [CW-1:0]        seat_ext,
    input  wire logic [CW-1:0]        cnt,
    input  wire rnra_pkg::link_t      left_i,
    input  wire rnra_pkg::link_t      right_i,
    output rnra_pkg::link_t           link_o,
    output rnra_pkg::seat_state_t     st_next_o,
    output rnra_pkg::report_t         rep_o
);

    rnra_pkg::seat_state_t state_reg;
    rnra_pkg::seat_state_t state_next;

    logic active;
    logic hit;
    logic req;
    logic rel;
    logic hungry;
    logic left_eat;
    logic right_eat_after;
    logic grant_self;
    logic grant_l;
    logic grant_r;

    always_comb begin
        active   = (CW'(IDX) < cnt);
        hit      = fire && active && (seat_ext == CW'(IDX));
        req      = hit && (op == rnra_pkg::OP_REQUEST) && (state_reg == rnra_pkg::SEAT_THINK);
        rel      = hit && (op == rnra_pkg::OP_RELEASE) && (state_reg == rnra_pkg::SEAT_EAT);
        hungry   = active && (state_reg == rnra_pkg::SEAT_HUNGRY);
        // a releasing neighbor counts as no longer eating
        left_eat = (left_i.state == rnra_pkg::SEAT_EAT) && !left_i.rel;
        right_eat_after = ((right_i.state == rnra_pkg::SEAT_EAT) && !right_i.rel)
                          || right_i.grant_l;
        grant_self = req && (left_i.state != rnra_pkg::SEAT_EAT)
                         && (right_i.state != rnra_pkg::SEAT_EAT);
        // left neighbor of the releaser is tested first, on the old states
        grant_l  = hungry && right_i.rel && !left_eat;
        // right neighbor sees the left grant already applied
        grant_r  = hungry && left_i.rel && !grant_l && !right_eat_after;

        state_next = state_reg;
        if (req) begin
            state_next = grant_self ? rnra_pkg::SEAT_EAT : rnra_pkg::SEAT_HUNGRY;
        end else if (rel) begin
            state_next = rnra_pkg::SEAT_THINK;
        end else if (grant_l || grant_r) begin
            state_next = rnra_pkg::SEAT_EAT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rnra_pkg::SEAT_THINK;
        end else begin
            state_reg <= state_next;
        end
    end

    assign link_o.state   = state_reg;
    assign link_o.rel     = rel;
    assign link_o.grant_l = grant_l;

    assign st_next_o      = state_next;

    assign rep_o.err      = hit && !req && !rel;
    assign rep_o.self_g   = grant_self;
    assign rep_o.left_g   = grant_l;
    assign rep_o.right_g  = grant_r;

endmodule
`default_nettype wire

### src/ring_neighbour_resource_arbiter_top.sv
// Top level of the ring neighbour resource arbiter: seat cells and result register.
//
//  channel | dir | handshake          | word layout (low bit first)
//  --------+-----+--------------------+-------------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | operation[0], seat[3:1], zero pad [7:4]
//  m_      | out | m_tvalid/m_tready  | status[1:0], self[2], left[3], right[4],
//          |     |                    | eating_mask[12:5], hungry_mask[20:13], pad [23:21]
//  cfg_    | in  | cfg_wen            | seat_count[3:0]
//
//  One word per cycle while s_tready is high: an accepted word updates the seat cells
//  and loads its result into the output register at the accepting edge.
//  The cost of a word is the cell row: each seat sees only its two ring neighbors, and
//  the right neighbor's decision looks one cell further for the left grant.
//  Reset (aresetn low, synchronous) sets every seat thinking and seat_count to 8.
//  A stalled result holds; s_tready stays high while the output register is empty or
//  being taken, so input is accepted alongside a result that is leaving.
`default_nettype none
module ring_neighbour_resource_arbiter_top #(
    parameter int MAX_SEATS = rnra_pkg::MAX_SEATS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // operation[0], seat[3:1], zero[7:4]
    input  wire logic [rnra_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // status[1:0], self_granted[2], left_granted[3], right_granted[4],
    // eating_mask[12:5], hungry_mask[20:13], zero[23:21]
    output      logic [rnra_pkg::M_DATA_W-1:0] m_tdata,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          cfg_wen,
    input  wire logic [rnra_pkg::COUNT_W-1:0]  cfg_wdata
);

    localparam int CW = ($clog2(MAX_SEATS + 1) > rnra_pkg::COUNT_W)
                        ? $clog2(MAX_SEATS + 1) : rnra_pkg::COUNT_W;
    localparam int IW = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;

    logic [rnra_pkg::COUNT_W-1:0]  seat_count_reg;
    logic                          m_tvalid_reg;
    logic [rnra_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [rnra_pkg::M_DATA_W-1:0] m_tdata_next;

    logic                          fire;
    logic                          op;
    logic [rnra_pkg::SEAT_W-1:0]   seat;
    logic [CW-1:0]                 seat_ext;
    logic [CW-1:0]                 cnt;
    logic [CW-1:0]                 cfg_ext;
    logic [IW-1:0]                 last_idx;
    logic                          out_of_range;

    rnra_pkg::link_t               link [MAX_SEATS];
    rnra_pkg::link_t               left_link [MAX_SEATS];
    rnra_pkg::link_t               right_link [MAX_SEATS];
    rnra_pkg::seat_state_t         st_next [MAX_SEATS];
    rnra_pkg::report_t             rep [MAX_SEATS];

    logic [MAX_SEATS-1:0]          err_v;
    logic [MAX_SEATS-1:0]          self_v;
    logic [MAX_SEATS-1:0]          left_v;
    logic [MAX_SEATS-1:0]          right_v;
    logic [rnra_pkg::MASK_W-1:0]   eat_mask;
    logic [rnra_pkg::MASK_W-1:0]   hun_mask;
    logic [rnra_pkg::STATUS_W-1:0] status;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign op       = s_tdata[0];
    assign seat     = s_tdata[rnra_pkg::SEAT_W:1];
    assign seat_ext = CW'(seat);

    // clamp the seat count to 1..MAX_SEATS
    always_comb begin
        cfg_ext = CW'(seat_count_reg);
        if (cfg_ext == '0) begin
            cnt = CW'(1);
        end else if (cfg_ext > CW'(MAX_SEATS)) begin
            cnt = CW'(MAX_SEATS);
        end else begin
            cnt = cfg_ext;
        end
    end

    assign last_idx     = IW'(cnt - CW'(1));
    assign out_of_range = (seat_ext >= cnt);

    // ring wiring: seat 0's left is the last live seat, the last live seat's right is seat 0
    for (genvar i = 0; i < MAX_SEATS; i++) begin : g_cell
        if (i == 0) begin : g_left0
            assign left_link[i] = link[last_idx];
        end else begin : g_leftn
            assign left_link[i] = link[i-1];
        end

        if (i == MAX_SEATS - 1) begin : g_rightl
            assign right_link[i] = link[0];
        end else begin : g_rightn
            assign right_link[i] = (CW'(i) == cnt - CW'(1)) ? link[0] : link[i+1];
        end

        rnra_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .fire      (fire),
            .op        (op),
            .seat_ext  (seat_ext),
            .cnt       (cnt),
            .left_i    (left_link[i]),
            .right_i   (right_link[i]),
            .link_o    (link[i]),
            .st_next_o (st_next[i]),
            .rep_o     (rep[i])
        );

        assign err_v[i]   = rep[i].err;
        assign self_v[i]  = rep[i].self_g;
        assign left_v[i]  = rep[i].left_g;
        assign right_v[i] = rep[i].right_g;
    end

    // masks show seats 0..7 after the step
    for (genvar b = 0; b < rnra_pkg::MASK_W; b++) begin : g_mask
        if (b < MAX_SEATS) begin : g_live
            assign eat_mask[b] = (st_next[b] == rnra_pkg::SEAT_EAT);
            assign hun_mask[b] = (st_next[b] == rnra_pkg::SEAT_HUNGRY);
        end else begin : g_none
            assign eat_mask[b] = 1'b0;
            assign hun_mask[b] = 1'b0;
        end
    end

    always_comb begin
        if (out_of_range) begin
            status = rnra_pkg::STATUS_RANGE;
        end else if (|err_v) begin
            status = rnra_pkg::STATUS_STATE;
        end else begin
            status = rnra_pkg::STATUS_OK;
        end
        m_tdata_next = {3'b000, hun_mask, eat_mask, |right_v, |left_v, |self_v, status};
    end

    // seat count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seat_count_reg <= rnra_pkg::SEAT_COUNT_RST;
        end else if (cfg_wen) begin
            seat_count_reg <= cfg_wdata;
        end
    end

    // output register: load on accept, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

### src/rnra_checker.sv
// Port-level checks of the ring neighbour resource arbiter, bound to the top level.
`default_nettype none
module rnra_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [rnra_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready
);

    // hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // a seat is never eating and hungry at once
    a_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[12:5] & m_tdata[20:13]) == 8'd0))
        else $error("seat both eating and hungry");

    // a rejected word grants nothing
    a_no_grant_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != rnra_pkg::STATUS_OK) |-> (m_tdata[4:2] == 3'b000))
        else $error("grant reported on a rejected word");

    // a request grant and a release grant never share a word
    a_grant_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[3] && !m_tdata[4])
        else $error("self grant mixed with neighbor grant");

    // a result appears only in the cycle after an accepted word
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result word without an accepted input word");

endmodule

bind ring_neighbour_resource_arbiter_top rnra_checker u_rnra_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the ring neighbour resource arbiter.
`default_nettype none
module tb;
    import rnra_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;   // cycles without any handshake
    localparam int PHASE_WORDS    = 150;

    // one request or release as it travels on the input channel
    typedef struct packed {
        logic       op;
        logic [2:0] seat;
    } seat_cmd_t;

    // one result word, split into its fields
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                self_g;
        logic                left_g;
        logic                right_g;
        logic [MASK_W-1:0]   eat_mask;
        logic [MASK_W-1:0]   hungry_mask;
    } grant_report_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_wen   = 1'b0;
    logic [COUNT_W-1:0]     cfg_wdata = '0;

    // shadow of the arbiter: per-seat state and the seat_count register
    seat_state_t            seats [MAX_SEATS_DEF] = '{default: SEAT_THINK};
    logic [COUNT_W-1:0]     ring_size = SEAT_COUNT_RST;

    seat_cmd_t              cmd_q[$];        // commands not yet offered
    grant_report_t          report_q[$];     // reports owed by the block, oldest first
    int                     errors        = 0;
    int                     send_idle_pct = 0;
    int                     take_idle_pct = 0;
    int                     send_gap      = 0;
    int                     take_gap      = 0;
    int                     quiet_cycles  = 0;

    ring_neighbour_resource_arbiter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial begin : clock_gen
        forever #4 aclk = ~aclk;
    end

    // Seats in the live ring: a zero count acts as one seat, large counts clip to the max.
    function automatic int live_seats();
        if (ring_size == 0)
            return 1;
        if (ring_size > MAX_SEATS_DEF)
            return MAX_SEATS_DEF;
        return int'(ring_size);
    endfunction

    // Let a hungry seat start eating when neither ring neighbor eats.
    function automatic logic seat_eats_if_free(int s, int c);
        int l;
        int r;
        l = (s + c - 1) % c;
        r = (s + 1) % c;
        if (seats[s] == SEAT_HUNGRY && seats[l] != SEAT_EAT && seats[r] != SEAT_EAT) begin
            seats[s] = SEAT_EAT;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one command to the shadow ring and return the report it must produce.
    function automatic grant_report_t arbitrate(logic op, logic [2:0] seat);
        grant_report_t rep;
        int c;
        int s;
        rep = '0;
        c   = live_seats();
        s   = int'(seat);
        if (s >= c) begin
            rep.status = STATUS_RANGE;
        end else if (op == OP_REQUEST) begin
            if (seats[s] != SEAT_THINK) begin
                rep.status = STATUS_STATE;
            end else begin
                seats[s]   = SEAT_HUNGRY;
                rep.self_g = seat_eats_if_free(s, c);
            end
        end else begin
            if (seats[s] != SEAT_EAT) begin
                rep.status = STATUS_STATE;
            end else begin
                // left neighbor is retested first; in a two-seat ring it is also the right one
                seats[s]    = SEAT_THINK;
                rep.left_g  = seat_eats_if_free((s + c - 1) % c, c);
                rep.right_g = seat_eats_if_free((s + 1) % c, c);
            end
        end
        // seats past the live ring keep their state and still show in the masks
        for (int i = 0; i < MAX_SEATS_DEF; i++) begin
            rep.eat_mask[i]    = (seats[i] == SEAT_EAT);
            rep.hungry_mask[i] = (seats[i] == SEAT_HUNGRY);
        end
        return rep;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // Driver: offer queued commands, hold under backpressure, insert short random gaps.
    always @(posedge aclk) begin : cmd_driver
        seat_cmd_t cmd;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end else begin
            // predict at the edge that takes the word
            if (s_tvalid && s_tready)
                report_q.push_back(arbitrate(s_tdata[0], s_tdata[3:1]));
            if (s_tvalid && !s_tready) begin
                // hold the word until it is taken
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
                    // start a gap with s_tvalid low, this cycle included
                    send_gap = $urandom_range(2);
                    s_tvalid <= 1'b0;
                end else begin
                    cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0000, cmd.seat, cmd.op};
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: stall the result side in bursts and check each result word taken.
    always @(posedge aclk) begin : result_monitor
        grant_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            take_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (report_q.size() == 0) begin
                    $error("result word %06h arrived with nothing outstanding", m_tdata);
                    errors++;
                end else begin
                    want = report_q.pop_front();
                    check_field("status",        want.status,      m_tdata[1:0]);
                    check_field("self_granted",  want.self_g,      m_tdata[2]);
                    check_field("left_granted",  want.left_g,      m_tdata[3]);
                    check_field("right_granted", want.right_g,     m_tdata[4]);
                    check_field("eating_mask",   want.eat_mask,    m_tdata[12:5]);
                    check_field("hungry_mask",   want.hungry_mask, m_tdata[20:13]);
                    check_field("padding",       0,                m_tdata[23:21]);
                end
            end
            if (take_gap > 0) begin
                take_gap--;
                m_tready <= 1'b0;
            end else if (take_idle_pct != 0 && $urandom_range(99) < take_idle_pct) begin
                take_gap = $urandom_range(2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when neither channel has moved a word for too long.
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_cmd(logic op, logic [2:0] seat);
        cmd_q.push_back('{op: op, seat: seat});
    endtask

    // Wait until every command is taken and every result word has been checked.
    // Sample on the falling edge so the driver has settled.
    task automatic wait_drained();
        do @(negedge aclk);
        while (cmd_q.size() != 0 || s_tvalid || report_q.size() != 0);
        repeat (2) @(negedge aclk);
    endtask

    // Write seat_count while the block is idle; seat states carry over.
    task automatic write_seat_count(logic [COUNT_W-1:0] value);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        ring_size = value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int          phase_counts [12];
        int          c;
        logic        op;
        logic [2:0]  seat;

        phase_counts = '{0, 15, 3, 8, 2, 5, 1, 7, 4, 6, 9, 8};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Full ring: immediate grant, waiting seats, wrong-state ops, neighbor grants.
        write_seat_count(4'd8);
        push_cmd(OP_REQUEST, 3'd0);   // granted at once
        push_cmd(OP_REQUEST, 3'd1);   // waits on seat 0
        push_cmd(OP_REQUEST, 3'd7);   // waits on seat 0
        push_cmd(OP_REQUEST, 3'd0);   // already eating
        push_cmd(OP_RELEASE, 3'd1);   // hungry, not eating
        push_cmd(OP_RELEASE, 3'd2);   // thinking, not eating
        push_cmd(OP_RELEASE, 3'd0);   // both neighbors start eating
        push_cmd(OP_REQUEST, 3'd4);
        push_cmd(OP_REQUEST, 3'd3);
        push_cmd(OP_REQUEST, 3'd5);
        push_cmd(OP_REQUEST, 3'd6);
        push_cmd(OP_RELEASE, 3'd4);   // left and right both granted
        push_cmd(OP_RELEASE, 3'd7);   // left still blocked, right thinking
        push_cmd(OP_RELEASE, 3'd5);   // only the right neighbor is granted
        push_cmd(OP_RELEASE, 3'd1);
        push_cmd(OP_RELEASE, 3'd3);
        push_cmd(OP_RELEASE, 3'd6);
        wait_drained();

        // One-seat ring: the seat is its own neighbor; other seats are out of range.
        write_seat_count(4'd1);
        push_cmd(OP_REQUEST, 3'd0);
        push_cmd(OP_REQUEST, 3'd3);
        push_cmd(OP_RELEASE, 3'd0);
        wait_drained();

        // Two-seat ring: the single neighbor is retested as the left one only.
        write_seat_count(4'd2);
        push_cmd(OP_REQUEST, 3'd0);
        push_cmd(OP_REQUEST, 3'd1);
        push_cmd(OP_RELEASE, 3'd0);
        push_cmd(OP_RELEASE, 3'd1);
        push_cmd(OP_REQUEST, 3'd7);
        wait_drained();

        // Random phases: each resizes the ring while seats may be busy, then drains.
        foreach (phase_counts[p]) begin
            write_seat_count(phase_counts[p][COUNT_W-1:0]);
            if (p == $size(phase_counts) - 1) begin
                // no idling at the end of the run
                send_idle_pct = 0;
                take_idle_pct = 0;
            end else if (p % 4 == 1) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end else begin
                send_idle_pct = (p % 2) ? 40 : 15;
                take_idle_pct = (p % 3 == 0) ? 40 : 20;
            end
            c = live_seats();
            for (int n = 0; n < PHASE_WORDS; n++) begin
                op = $urandom_range(1);
                // mostly seats in the live ring, some beyond it
                if ($urandom_range(9) != 0)
                    seat = $urandom_range(c - 1);
                else
                    seat = $urandom_range(MAX_SEATS_DEF - 1);
                push_cmd(op, seat);
            end
            wait_drained();
        end

        repeat (4) @(posedge aclk);
        if (errors == 0 && report_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
src/rnra_pkg.sv
src/rnra_cell.sv
src/ring_neighbour_resource_arbiter_top.sv
src/rnra_checker.sv
verif/tb.sv
